[src/sfr_pkg.sv]
// Shared types, codes and constants of the servo frame/reply engine.
// No dependencies; imported by the decoder, the top level and the testbench.
`timescale 1ns / 1ps

package sfr_pkg;

	// Store geometry
	localparam int FRAME_LENGTH = 10;
	localparam int REPLY_DEPTH  = 10;
	localparam int FA_W         = $clog2(FRAME_LENGTH);
	localparam int RA_W         = $clog2(REPLY_DEPTH);

	// Request/reply codes
	localparam logic [1:0] FUNC_REQUEST = 2'd0;
	localparam logic [1:0] FUNC_RX_BYTE = 2'd1;
	localparam logic [1:0] FUNC_RX_END  = 2'd2;

	localparam logic [1:0] MODE_GENERAL  = 2'd0;
	localparam logic [1:0] MODE_ID_QUERY = 2'd1;
	localparam logic [1:0] MODE_ACTION   = 2'd2;

	localparam logic [1:0] MAX_RETRIES_RST = 2'd2;

	// Frame and reply byte positions
	localparam logic [FA_W-1:0] POS_HEAD = FA_W'(0);
	localparam logic [FA_W-1:0] POS_SWAP = FA_W'(1);
	localparam logic [FA_W-1:0] POS_ID   = FA_W'(2);
	localparam logic [FA_W-1:0] POS_CMD  = FA_W'(3);
	localparam logic [FA_W-1:0] POS_D0   = FA_W'(4);
	localparam logic [FA_W-1:0] POS_D1   = FA_W'(5);
	localparam logic [FA_W-1:0] POS_D2   = FA_W'(6);
	localparam logic [FA_W-1:0] POS_D3   = FA_W'(7);
	localparam logic [FA_W-1:0] POS_SUM  = FA_W'(8);
	localparam logic [FA_W-1:0] POS_TAIL = FA_W'(FRAME_LENGTH - 1);

	// Byte values
	localparam logic [7:0] FRAME_TAIL = 8'hED;
	localparam logic [7:0] MARK_FC    = 8'hFC;
	localparam logic [7:0] MARK_CF    = 8'hCF;
	localparam logic [7:0] MARK_AA    = 8'hAA;
	localparam logic [7:0] ID_OFFSET  = 8'hEC;
	localparam logic [7:0] CMD_ONE    = 8'h01;
	localparam logic [7:0] CMD_TWO    = 8'h02;
	localparam logic [7:0] CMD_THREE  = 8'h03;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEND,
		ST_RD,
		ST_RESEND,
		ST_SWEEP,
		ST_LAST,
		ST_ANSWER
	} state_t;

	// Bytes gathered by the reply sweep for the decoder
	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] count;
		logic [7:0] head;
		logic [7:0] id;
		logic [7:0] cmd;
		logic [7:0] r0;
		logic [7:0] r1;
		logic [7:0] r2;
		logic [7:0] r3;
		logic [7:0] r6;
		logic [7:0] r7;
		logic [7:0] r8;
		logic [7:0] sum;
	} dec_in_t;

endpackage

[src/sfr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sfr_ram #(
	parameter int DEPTH = 10,
	parameter int WIDTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, then read into the registered read data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/sfr_decode.sv]
// Reply decoder: turns the swept reply bytes into the final answer.
// Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_decode import sfr_pkg::*; (
	input  dec_in_t     d,
	output logic [15:0] answer
);

	logic       markers_ok;
	logic       markers_bad;
	logic       id_zero;
	logic [7:0] id_wrap;

	assign markers_ok  = (d.r0 == MARK_FC) && (d.r1 == MARK_CF) && (d.r3 == MARK_AA);
	assign markers_bad = ((d.r0 != MARK_FC) && (d.r0 != 8'h00)) ||
	                     ((d.r1 != MARK_CF) && (d.r1 != 8'h00)) ||
	                     ((d.r3 != MARK_AA) && (d.r3 != 8'h00));
	assign id_zero     = (d.r0 == 8'h00) && (d.r1 == 8'h00) && (d.r2 == 8'h00) &&
	                     (d.r3 == 8'h00) && (d.r8 == 8'h00);
	assign id_wrap     = d.id + ID_OFFSET;

	// Select the answer by saved mode and command
	always_comb begin
		answer = 16'h0000;
		case (d.mode)
			MODE_GENERAL: begin
				if (d.count == 8'h00) begin
					answer = 16'h0000;
				end else if (d.cmd == CMD_ONE) begin
					if (d.head == MARK_FC) begin
						if (markers_ok) begin
							answer = {8'h00, d.r2};
						end else if (markers_bad) begin
							answer = {8'h00, d.id} + {8'h00, ID_OFFSET};
						end
					end else begin
						answer = {8'h00, d.r0} - {8'h00, MARK_AA} - {8'h00, d.id};
					end
				end else if ((d.cmd == CMD_TWO) || (d.cmd == CMD_THREE)) begin
					answer = {d.r6, d.r7};
				end
			end
			MODE_ID_QUERY: begin
				if (markers_ok && (d.sum == d.r8)) begin
					answer = {8'h00, d.r2};
				end else if (id_zero) begin
					answer = 16'h0000;
				end else begin
					answer = {8'h00, id_wrap};
				end
			end
			default: begin
				answer = {8'h00, d.count};
			end
		endcase
	end

endmodule

[src/servo_frame_reply_engine.sv]
// Top level of the servo frame/reply engine: sequencer, frame and reply stores, output register.
// Depends on sfr_pkg, sfr_ram and sfr_decode.
`timescale 1ns / 1ps

// A request transaction builds a ten-byte frame and sends it out one byte per cycle
// while the output register is free, recording it in the frame store. A
// received-byte transaction writes the reply store when its position past the echo
// fits. An end transaction either starts a resend or sweeps the reply store one entry
// per cycle (nine reads), then finishes the decode in ST_LAST and ST_ANSWER.
// A resend reads each frame byte back from the frame store in ST_RD and sends it
// from ST_RESEND before it reads the next byte. One transaction is worked on
// at a time: in_ready is high only when the sequencer is idle, while a finished
// result may still wait in the output register. Output backpressure stalls sending,
// resending and the answer. The reply store clears at once through per-entry valid bits.
module servo_frame_reply_engine import sfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [1:0]  protocol_mode,
	input  logic [7:0]  head,
	input  logic [7:0]  servo_id,
	input  logic [7:0]  command,
	input  logic [7:0]  data_0,
	input  logic [7:0]  data_1,
	input  logic [7:0]  data_2,
	input  logic [7:0]  data_3,
	input  logic [7:0]  reply_byte,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [7:0]  tx_byte,
	output logic        last,
	output logic [15:0] answer,
	// configuration
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_wr_data
);

	state_t st_q, st_d;

	logic            in_acc;
	logic            slot_free;
	logic [FA_W-1:0] idx_q;
	logic [1:0]      max_retries_q;
	logic [1:0]      mode_q;
	logic [1:0]      retry_q;
	logic [7:0]      rcv_count_q;
	logic [REPLY_DEPTH-1:0] rvalid_q;

	// request holding registers
	logic [7:0] head_q, id_q, cmd_q, d0_q, d1_q, d2_q, d3_q, chk_q;
	logic [7:0] send_byte;

	// store ports
	logic            fram_we, fram_re;
	logic [7:0]      fram_rdata;
	logic            rply_we, rply_re;
	logic [7:0]      rply_rdata;
	logic [7:0]      wpos;
	logic            rx_store;
	logic            sweep_in_range;

	// sweep pipeline
	logic            sweep_s1;
	logic [FA_W-1:0] idx_s1;
	logic            rv_s1;
	logic [7:0]      rbyte_s1;

	// gathered decode bytes
	logic [7:0] hd_q, idc_q, cmc_q, r0_q, r1_q, r2_q, r3_q, r6_q, r7_q, r8_q, sum_q;
	dec_in_t    dec_in;
	logic [15:0] dec_answer;

	// sequencer controls
	logic        go_resend;
	logic        idx_inc;
	logic        out_load;
	logic        out_kind_d;
	logic [7:0]  out_tx_d;
	logic        out_last_d;
	logic [15:0] out_ans_d;

	// output register
	logic        out_valid_q;
	logic        kind_q;
	logic [7:0]  tx_q;
	logic        last_q;
	logic [15:0] ans_q;

	assign in_ready  = (st_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	assign go_resend = (mode_q == MODE_GENERAL) && (rcv_count_q == 8'h00) &&
	                   (retry_q < max_retries_q);

	// Reply store write position past the echo
	assign wpos     = rcv_count_q - 8'(FRAME_LENGTH);
	assign rx_store = (rcv_count_q >= 8'(FRAME_LENGTH)) && (wpos < 8'(REPLY_DEPTH));
	assign rply_we  = in_acc && (func == FUNC_RX_BYTE) && rx_store;

	assign sweep_in_range = (8'(idx_q) < 8'(REPLY_DEPTH));
	assign rply_re        = (st_q == ST_SWEEP) && sweep_in_range;

	// Frame byte for the current send position
	always_comb begin
		case (idx_q)
			POS_HEAD: send_byte = head_q;
			POS_SWAP: send_byte = {head_q[3:0], head_q[7:4]};
			POS_ID:   send_byte = id_q;
			POS_CMD:  send_byte = cmd_q;
			POS_D0:   send_byte = d0_q;
			POS_D1:   send_byte = d1_q;
			POS_D2:   send_byte = d2_q;
			POS_D3:   send_byte = d3_q;
			POS_SUM:  send_byte = chk_q;
			POS_TAIL: send_byte = FRAME_TAIL;
			default:  send_byte = 8'h00;
		endcase
	end

	// Next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (func)
						FUNC_REQUEST: st_d = ST_SEND;
						FUNC_RX_END:  st_d = go_resend ? ST_RD : ST_SWEEP;
						default:      st_d = ST_IDLE;
					endcase
				end
			end
			ST_SEND: begin
				if (slot_free && (idx_q == POS_TAIL)) begin
					st_d = ST_IDLE;
				end
			end
			ST_RD: st_d = ST_RESEND;
			ST_RESEND: begin
				if (slot_free) begin
					st_d = (idx_q == POS_TAIL) ? ST_IDLE : ST_RD;
				end
			end
			ST_SWEEP: begin
				if (idx_q == POS_SUM) begin
					st_d = ST_LAST;
				end
			end
			ST_LAST: st_d = ST_ANSWER;
			ST_ANSWER: begin
				if (slot_free) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		fram_we    = 1'b0;
		fram_re    = 1'b0;
		idx_inc    = 1'b0;
		out_load   = 1'b0;
		out_kind_d = 1'b0;
		out_tx_d   = 8'h00;
		out_last_d = 1'b0;
		out_ans_d  = 16'h0000;
		case (st_q)
			ST_SEND: begin
				if (slot_free) begin
					fram_we    = 1'b1;
					idx_inc    = 1'b1;
					out_load   = 1'b1;
					out_tx_d   = send_byte;
					out_last_d = (idx_q == POS_TAIL);
				end
			end
			ST_RD: begin
				fram_re = 1'b1;
			end
			ST_RESEND: begin
				if (slot_free) begin
					idx_inc    = 1'b1;
					out_load   = 1'b1;
					out_tx_d   = fram_rdata;
					out_last_d = (idx_q == POS_TAIL);
				end
			end
			ST_SWEEP: begin
				fram_re = 1'b1;
				idx_inc = 1'b1;
			end
			ST_ANSWER: begin
				if (slot_free) begin
					out_load   = 1'b1;
					out_kind_d = 1'b1;
					out_ans_d  = dec_answer;
				end
			end
			default: begin
				fram_we = 1'b0;
			end
		endcase
	end

	// Frame store: written while sending, read on resend and sweep
	sfr_ram #(.DEPTH(FRAME_LENGTH), .WIDTH(8)) u_frame_ram (
		.clk   (clk),
		.we    (fram_we),
		.waddr (idx_q),
		.wdata (send_byte),
		.re    (fram_re),
		.raddr (idx_q),
		.rdata (fram_rdata)
	);

	// Reply store: written by received bytes, read by the sweep
	sfr_ram #(.DEPTH(REPLY_DEPTH), .WIDTH(8)) u_reply_ram (
		.clk   (clk),
		.we    (rply_we),
		.waddr (wpos[RA_W-1:0]),
		.wdata (reply_byte),
		.re    (rply_re),
		.raddr (idx_q[RA_W-1:0]),
		.rdata (rply_rdata)
	);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ST_IDLE;
			idx_q         <= '0;
			max_retries_q <= MAX_RETRIES_RST;
			mode_q        <= MODE_GENERAL;
			retry_q       <= 2'd0;
			rcv_count_q   <= 8'h00;
			rvalid_q      <= '0;
			sweep_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			st_q     <= st_d;
			sweep_s1 <= (st_q == ST_SWEEP);

			if (cfg_wr_en) begin
				max_retries_q <= cfg_wr_data;
			end

			// advance or restart the position counter
			if (in_acc) begin
				idx_q <= '0;
			end else if (idx_inc) begin
				idx_q <= idx_q + FA_W'(1);
			end

			// request, received byte, end with resend
			if (in_acc && (func == FUNC_REQUEST)) begin
				mode_q      <= protocol_mode;
				retry_q     <= 2'd0;
				rcv_count_q <= 8'h00;
				rvalid_q    <= '0;
			end else if (in_acc && (func == FUNC_RX_BYTE)) begin
				if (rcv_count_q != 8'hFF) begin
					rcv_count_q <= rcv_count_q + 8'd1;
				end
				if (rx_store) begin
					rvalid_q[wpos[RA_W-1:0]] <= 1'b1;
				end
			end else if (in_acc && (func == FUNC_RX_END) && go_resend) begin
				retry_q     <= retry_q + 2'd1;
				rcv_count_q <= 8'h00;
				rvalid_q    <= '0;
			end

			// hold result until taken, drop when taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_acc && (func == FUNC_REQUEST)) begin
			head_q <= head;
			id_q   <= servo_id;
			cmd_q  <= command;
			d0_q   <= data_0;
			d1_q   <= data_1;
			d2_q   <= data_2;
			d3_q   <= data_3;
			chk_q  <= servo_id + command + data_0 + data_1 + data_2 + data_3;
		end

		idx_s1 <= idx_q;
		rv_s1  <= sweep_in_range && rvalid_q[idx_q[RA_W-1:0]];

		if (out_load) begin
			kind_q <= out_kind_d;
			tx_q   <= out_tx_d;
			last_q <= out_last_d;
			ans_q  <= out_ans_d;
		end
	end

	// Never-written reply entries read as zero
	assign rbyte_s1 = rv_s1 ? rply_rdata : 8'h00;

	// Gather swept bytes and the reply checksum
	always_ff @(posedge clk) begin
		if (sweep_s1) begin
			case (idx_s1)
				POS_HEAD: begin
					r0_q <= rbyte_s1;
					hd_q <= fram_rdata;
				end
				POS_SWAP: r1_q <= rbyte_s1;
				POS_ID: begin
					r2_q  <= rbyte_s1;
					idc_q <= fram_rdata;
					sum_q <= rbyte_s1;
				end
				POS_CMD: begin
					r3_q  <= rbyte_s1;
					cmc_q <= fram_rdata;
					sum_q <= sum_q + rbyte_s1;
				end
				POS_D0, POS_D1: sum_q <= sum_q + rbyte_s1;
				POS_D2: begin
					r6_q  <= rbyte_s1;
					sum_q <= sum_q + rbyte_s1;
				end
				POS_D3: begin
					r7_q  <= rbyte_s1;
					sum_q <= sum_q + rbyte_s1;
				end
				POS_SUM: r8_q <= rbyte_s1;
				default: r8_q <= r8_q;
			endcase
		end
	end

	assign dec_in = '{
		mode:  mode_q,
		count: rcv_count_q,
		head:  hd_q,
		id:    idc_q,
		cmd:   cmc_q,
		r0:    r0_q,
		r1:    r1_q,
		r2:    r2_q,
		r3:    r3_q,
		r6:    r6_q,
		r7:    r7_q,
		r8:    r8_q,
		sum:   sum_q
	};

	sfr_decode u_decode (
		.d      (dec_in),
		.answer (dec_answer)
	);

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign tx_byte   = tx_q;
	assign last      = last_q;
	assign answer    = ans_q;

`ifndef ASSERT_OFF
	// The last byte of a frame always returns the sequencer to idle
	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && !out_kind_d && out_last_d) |=> (st_q == ST_IDLE))
		else $error("frame end did not return to idle");

	// A request clears the reply store, the byte count and the retry count
	a_request_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (func == FUNC_REQUEST)) |=>
		((rvalid_q == '0) && (rcv_count_q == 8'h00) && (retry_q == 2'd0)))
		else $error("request did not clear reply state");

	// The byte count only moves up except on request or end
	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_acc && ((func == FUNC_REQUEST) || (func == FUNC_RX_END))) |=>
		(rcv_count_q >= $past(rcv_count_q)))
		else $error("received count dropped unexpectedly");
`endif

endmodule

[tb/servo_frame_reply_engine_checker.sv]
`timescale 1ns / 1ps
// Result checker for the servo frame/reply engine: watches both channels and the
// retry-limit port, predicts the result stream and compares it field by field.
// Depends on sfr_pkg.

module servo_frame_reply_engine_checker import sfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  func,
	input  logic [1:0]  protocol_mode,
	input  logic [7:0]  head,
	input  logic [7:0]  servo_id,
	input  logic [7:0]  command,
	input  logic [7:0]  data_0,
	input  logic [7:0]  data_1,
	input  logic [7:0]  data_2,
	input  logic [7:0]  data_3,
	input  logic [7:0]  reply_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        kind,
	input  logic [7:0]  tx_byte,
	input  logic        last,
	input  logic [15:0] answer,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_wr_data,
	output int          fail_count,
	output int          results_pending
);

	localparam logic KIND_TX     = 1'b0;
	localparam logic KIND_ANSWER = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [7:0]  tx_byte;
		logic        last;
		logic [15:0] answer;
	} link_result_t;

	// Shadow copy of the engine state
	logic [7:0] frame_bytes [FRAME_LENGTH];
	logic [7:0] reply_bytes [REPLY_DEPTH];
	logic [7:0] byte_count;
	logic [1:0] retries_used;
	logic [1:0] retry_limit;
	logic [1:0] saved_mode;

	link_result_t link_results_q [$];

	initial begin
		fail_count      = 0;
		results_pending = 0;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		fail_count++;
	endtask

	function automatic link_result_t make_result(input logic k, input logic [7:0] tx,
			input logic l, input logic [15:0] ans);
		link_result_t r;
		r.kind    = k;
		r.tx_byte = tx;
		r.last    = l;
		r.answer  = ans;
		return r;
	endfunction

	task automatic clear_reply();
		foreach (reply_bytes[k]) reply_bytes[k] = 8'h00;
		byte_count = 8'd0;
	endtask

	// Queue the whole frame as transmit results
	task automatic queue_frame();
		for (int k = 0; k < FRAME_LENGTH; k++)
			link_results_q.push_back(make_result(KIND_TX, frame_bytes[k], k == FRAME_LENGTH - 1,
				16'h0000));
	endtask

	function automatic logic [15:0] general_answer();
		logic [7:0] h, sid, c, r0, r1, r3;
		h   = frame_bytes[POS_HEAD];
		sid = frame_bytes[POS_ID];
		c   = frame_bytes[POS_CMD];
		r0  = reply_bytes[0];
		r1  = reply_bytes[1];
		r3  = reply_bytes[3];
		if (c == CMD_ONE) begin
			if (h == MARK_FC) begin
				if (r0 == MARK_FC && r1 == MARK_CF && r3 == MARK_AA)
					return {8'h00, reply_bytes[2]};
				// a byte that is neither its marker nor zero means a garbled reply
				if ((r0 != MARK_FC && r0 != 8'h00) || (r1 != MARK_CF && r1 != 8'h00) ||
						(r3 != MARK_AA && r3 != 8'h00))
					return 16'(sid) + 16'(ID_OFFSET);
				return 16'h0000;
			end
			return 16'(r0) - 16'(MARK_AA) - 16'(sid);
		end
		if (c == CMD_TWO || c == CMD_THREE)
			return {reply_bytes[6], reply_bytes[7]};
		return 16'h0000;
	endfunction

	function automatic logic [15:0] id_query_answer();
		logic [7:0] csum, wrapped;
		csum = 8'h00;
		for (int k = 2; k < 8; k++)
			csum = csum + reply_bytes[k];
		if (reply_bytes[0] == MARK_FC && reply_bytes[1] == MARK_CF &&
				reply_bytes[3] == MARK_AA && csum == reply_bytes[8])
			return {8'h00, reply_bytes[2]};
		if (reply_bytes[0] == 8'h00 && reply_bytes[1] == 8'h00 && reply_bytes[2] == 8'h00 &&
				reply_bytes[3] == 8'h00 && reply_bytes[8] == 8'h00)
			return 16'h0000;
		wrapped = frame_bytes[POS_ID] + ID_OFFSET;
		return {8'h00, wrapped};
	endfunction

	// Decode on reception end, or resend while retries remain
	task automatic end_of_reply();
		logic [15:0] ans;
		if (saved_mode == MODE_GENERAL && byte_count == 8'd0 && retries_used < retry_limit) begin
			retries_used++;
			clear_reply();
			queue_frame();
		end else begin
			if (saved_mode == MODE_GENERAL)
				ans = (byte_count == 8'd0) ? 16'h0000 : general_answer();
			else if (saved_mode == MODE_ID_QUERY)
				ans = id_query_answer();
			else
				ans = {8'h00, byte_count};
			link_results_q.push_back(make_result(KIND_ANSWER, 8'h00, 1'b0, ans));
		end
	endtask

	task automatic take_item();
		logic [7:0] csum;
		int pos;
		case (func)
			FUNC_REQUEST: begin
				frame_bytes[POS_HEAD] = head;
				frame_bytes[POS_SWAP] = {head[3:0], head[7:4]};
				frame_bytes[POS_ID]   = servo_id;
				frame_bytes[POS_CMD]  = command;
				frame_bytes[POS_D0]   = data_0;
				frame_bytes[POS_D1]   = data_1;
				frame_bytes[POS_D2]   = data_2;
				frame_bytes[POS_D3]   = data_3;
				csum = 8'h00;
				for (int k = 2; k < 8; k++)
					csum = csum + frame_bytes[k];
				frame_bytes[POS_SUM]  = csum;
				frame_bytes[POS_TAIL] = FRAME_TAIL;
				saved_mode   = protocol_mode;
				retries_used = 2'd0;
				clear_reply();
				queue_frame();
			end
			FUNC_RX_BYTE: begin
				// skip the echo, store what fits, saturate the count
				pos = byte_count;
				if (pos >= FRAME_LENGTH && pos - FRAME_LENGTH < REPLY_DEPTH)
					reply_bytes[pos - FRAME_LENGTH] = reply_byte;
				if (byte_count != 8'd255)
					byte_count++;
			end
			FUNC_RX_END: end_of_reply();
			default: ;
		endcase
	endtask

	task automatic check_result();
		link_result_t want;
		if (link_results_q.size() == 0) begin
			report_mismatch("result with nothing pending (answer)", answer, 0);
			return;
		end
		want = link_results_q.pop_front();
		if (kind !== want.kind)       report_mismatch("kind", kind, want.kind);
		if (tx_byte !== want.tx_byte) report_mismatch("tx_byte", tx_byte, want.tx_byte);
		if (last !== want.last)       report_mismatch("last", last, want.last);
		if (answer !== want.answer)   report_mismatch("answer", answer, want.answer);
	endtask

	// Check the leaving transaction first: it always belongs to an earlier item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (frame_bytes[k]) frame_bytes[k] = 8'h00;
			clear_reply();
			retries_used = 2'd0;
			saved_mode   = MODE_GENERAL;
			retry_limit  = MAX_RETRIES_RST;
			link_results_q.delete();
		end else begin
			if (out_valid && out_ready)
				check_result();
			if (cfg_wr_en)
				retry_limit = cfg_wr_data;
			if (in_valid && in_ready)
				take_item();
		end
		results_pending <= link_results_q.size();
	end

endmodule

[tb/servo_frame_reply_engine_test.sv]
`timescale 1ns / 1ps
// Testbench top for the servo frame/reply engine: clock, reset, request and reply
// traffic, retry-limit writes and the verdict.
// Depends on sfr_pkg, servo_frame_reply_engine and servo_frame_reply_engine_checker.

module servo_frame_reply_engine_test;
	import sfr_pkg::*;

	localparam int         CLK_HALF      = 2;
	localparam int         RESET_CYCLES  = 6;
	localparam int         HOLD_CYCLES   = 300;
	localparam int         SETTLE_CYCLES = 30;
	localparam int         PHASE_ITEMS   = 16;
	localparam int         RUN_LIMIT_NS  = 2_000_000;
	localparam logic [1:0] FUNC_UNUSED   = 2'd3;
	localparam logic [1:0] MODE_SPARE    = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [1:0]  mode;
		logic [7:0]  head;
		logic [7:0]  sid;
		logic [7:0]  cmd;
		logic [31:0] data;
		logic [7:0]  rbyte;
	} link_item_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        in_valid      = 1'b0;
	logic        in_ready;
	logic [1:0]  func          = FUNC_REQUEST;
	logic [1:0]  protocol_mode = MODE_GENERAL;
	logic [7:0]  head          = 8'h00;
	logic [7:0]  servo_id      = 8'h00;
	logic [7:0]  command       = 8'h00;
	logic [7:0]  data_0        = 8'h00;
	logic [7:0]  data_1        = 8'h00;
	logic [7:0]  data_2        = 8'h00;
	logic [7:0]  data_3        = 8'h00;
	logic [7:0]  reply_byte    = 8'h00;
	logic        out_valid;
	logic        out_ready     = 1'b0;
	logic        kind;
	logic [7:0]  tx_byte;
	logic        last;
	logic [15:0] answer;
	logic        cfg_wr_en     = 1'b0;
	logic [1:0]  cfg_wr_data   = 2'd0;

	int   fail_count;
	int   results_pending;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   items_sent    = 0;
	logic hold_go       = 1'b0;
	int   hold_count    = 0;

	servo_frame_reply_engine DUT (.*);

	servo_frame_reply_engine_checker reply_checker (.*);

	always #(CLK_HALF) clk = ~clk;

	// Receiver: one long hold-off once requested, random stalls otherwise
	always @(posedge clk) begin
		if (hold_go && hold_count < HOLD_CYCLES) begin
			out_ready  <= 1'b0;
			hold_count <= hold_count + 1;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("servo_frame_reply_engine regression: fail");
		$finish;
	end

	function automatic link_item_t random_item(input logic [1:0] f);
		link_item_t it;
		it.func  = f;
		it.mode  = 2'($urandom);
		it.head  = 8'($urandom);
		it.sid   = 8'($urandom);
		it.cmd   = 8'($urandom);
		it.data  = $urandom;
		it.rbyte = 8'($urandom);
		return it;
	endfunction

	// Offer one transaction and hold it until it is taken
	task automatic send(input link_item_t it);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		func          <= it.func;
		protocol_mode <= it.mode;
		head          <= it.head;
		servo_id      <= it.sid;
		command       <= it.cmd;
		data_0        <= it.data[7:0];
		data_1        <= it.data[15:8];
		data_2        <= it.data[23:16];
		data_3        <= it.data[31:24];
		reply_byte    <= it.rbyte;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (it.func != FUNC_UNUSED)
			items_sent++;
	endtask

	task automatic send_request(input logic [1:0] mode, input logic [7:0] hd, sid, cmd,
			input logic [31:0] data);
		link_item_t it;
		it      = random_item(FUNC_REQUEST);
		it.mode = mode;
		it.head = hd;
		it.sid  = sid;
		it.cmd  = cmd;
		it.data = data;
		send(it);
	endtask

	task automatic send_byte(input logic [7:0] b);
		link_item_t it;
		it       = random_item(FUNC_RX_BYTE);
		it.rbyte = b;
		send(it);
	endtask

	task automatic send_end();
		send(random_item(FUNC_RX_END));
	endtask

	// Drop valid and wait until every result is out and the engine has gone quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_retry_limit(input logic [1:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// One request, its echo, a reply of some shape and the end of reception
	task automatic run_exchange();
		logic [1:0] mode;
		logic [7:0] hd, cmd, csum;
		logic [7:0] reply [12];
		int pick, style, len;
		pick = $urandom_range(0, 99);
		mode = (pick < 40) ? MODE_GENERAL : (pick < 75) ? MODE_ID_QUERY :
			(pick < 90) ? MODE_ACTION : MODE_SPARE;
		hd = $urandom_range(0, 1) ? MARK_FC : 8'($urandom);
		case ($urandom_range(0, 3))
			0:       cmd = CMD_ONE;
			1:       cmd = CMD_TWO;
			2:       cmd = CMD_THREE;
			default: cmd = 8'($urandom);
		endcase
		send_request(mode, hd, 8'($urandom), cmd, $urandom);

		// silent line: resend until the retries run out
		if (mode == MODE_GENERAL && $urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 5)) send_end();
			return;
		end

		// echo, occasionally cut short or overlong
		if ($urandom_range(0, 9) != 0)
			repeat (FRAME_LENGTH) send_byte(8'($urandom));
		else
			repeat ($urandom_range(0, 12)) send_byte(8'($urandom));

		foreach (reply[k]) reply[k] = 8'($urandom);
		style = $urandom_range(0, 3);
		case (style)
			0: begin
				reply[0] = MARK_FC;
				reply[1] = MARK_CF;
				reply[3] = MARK_AA;
				csum = 8'h00;
				for (int k = 2; k < 8; k++)
					csum = csum + reply[k];
				reply[8] = ($urandom_range(0, 3) == 0) ? csum ^ (8'h01 << $urandom_range(0, 7))
					: csum;
			end
			1: foreach (reply[k]) reply[k] = 8'h00;
			2: begin
				// markers and zeros mixed, hitting the no-reply paths
				reply[0] = $urandom_range(0, 1) ? MARK_FC : 8'h00;
				reply[1] = $urandom_range(0, 1) ? MARK_CF : 8'h00;
				reply[2] = $urandom_range(0, 1) ? reply[2] : 8'h00;
				reply[3] = $urandom_range(0, 1) ? MARK_AA : 8'h00;
				reply[8] = $urandom_range(0, 1) ? reply[8] : 8'h00;
			end
			default: ;
		endcase
		len = $urandom_range(0, 12);
		for (int k = 0; k < len; k++)
			send_byte(reply[k]);
		send_end();

		if ($urandom_range(0, 9) == 0)
			send_end();
		if ($urandom_range(0, 9) == 0)
			send(random_item(FUNC_UNUSED));
	endtask

	task automatic run_phase(input int s_idle, input int r_idle);
		int target;
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		target = items_sent + PHASE_ITEMS;
		while (items_sent < target)
			run_exchange();
		settle();
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// General mode, no reply: two resends at the reset limit, then a zero answer
		send_request(MODE_GENERAL, MARK_FC, 8'hFF, CMD_ONE, 32'h7F80FF00);
		repeat (3) send_end();
		send(random_item(FUNC_UNUSED));

		// Action mode counts the bytes seen
		send_request(MODE_ACTION, 8'hFF, 8'h00, 8'hFF, 32'h00000000);
		repeat (3) send_byte(8'hFF);
		send_end();

		// Spare mode decodes like action mode
		send_request(MODE_SPARE, 8'hA5, 8'h80, 8'h7F, 32'hFFFFFFFF);
		send_end();

		// Id query with an empty reply store
		send_request(MODE_ID_QUERY, 8'h00, 8'hFF, CMD_TWO, 32'h01020304);
		send_end();

		// General mode with one byte seen: no retry, command-two answer
		send_request(MODE_GENERAL, 8'h0F, 8'h14, CMD_TWO, 32'hF0E1D2C3);
		send_byte(8'h00);
		send_end();
		settle();

		write_retry_limit(2'd0);
		run_phase(34, 48);
		write_retry_limit(2'd3);
		run_phase(48, 34);

		// Long receiver hold-off so the engine fills and stalls its input
		write_retry_limit(2'd1);
		hold_go <= 1'b1;
		run_phase(0, 0);

		// Byte count saturation
		send_request(MODE_ACTION, 8'($urandom), 8'($urandom), 8'($urandom), $urandom);
		repeat (260) send_byte(8'($urandom));
		send_end();
		settle();

		if (fail_count == 0)
			$display("servo_frame_reply_engine regression: pass");
		else
			$display("servo_frame_reply_engine regression: fail");
		$finish;
	end

endmodule
